// ===== sv/vigenere_byte_cipher_core_defines.svh =====
// ----------------------------------------------------------------------------
// Vigenere byte cipher assertion macros
// Concurrent assertion helpers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef VIGENERE_BYTE_CIPHER_CORE_DEFINES_SVH
`define VIGENERE_BYTE_CIPHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define VBC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vbc assertion failed");
// Checked during reset as well.
`define VBC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vbc assertion failed");
`else
`define VBC_ASSERT(label, prop)
`define VBC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== sv/vbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Vigenere byte cipher package
// Action and register codes, alphabet constants and letter mapping functions.
// ----------------------------------------------------------------------------
package vbc_pkg;

  localparam int KEY_MAX_DEF = 64;
  // Wide enough to compare lengths and positions for any KEY_MAX up to 256.
  localparam int LEN_W = 9;

  // Input actions (in_tuser)
  localparam logic [1:0] ACT_KEY_WRITE = 2'd0;
  localparam logic [1:0] ACT_TEXT      = 2'd1;
  localparam logic [1:0] ACT_RESTART   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_LANGUAGE   = 2'd0;
  localparam logic [1:0] REG_DIRECTION  = 2'd1;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

  localparam logic LANG_EN = 1'b0;
  localparam logic DIR_ENC = 1'b0;

  localparam logic [5:0] ALPHA_EN = 6'd26;
  localparam logic [5:0] ALPHA_RU = 6'd33;

  typedef struct packed {
    logic       ok;
    logic [5:0] idx;
  } letter_t;

  // Letter index of a byte, case folded; ok low for a non-letter.
  function automatic letter_t letter_index(input logic lang, input logic [7:0] c);
    letter_t res;
    logic [7:0] d;
    res = '0;
    d   = '0;
    if (lang == LANG_EN) begin
      if (c >= 8'd65 && c <= 8'd90) begin
        d = c - 8'd65;
        res.ok = 1'b1;
      end else if (c >= 8'd97 && c <= 8'd122) begin
        d = c - 8'd97;
        res.ok = 1'b1;
      end
    end else begin
      if (c == 8'd168 || c == 8'd184) begin
        d = 8'd6;
        res.ok = 1'b1;
      end else if (c >= 8'd192 && c <= 8'd197) begin
        d = c - 8'd192;
        res.ok = 1'b1;
      end else if (c >= 8'd198 && c <= 8'd223) begin
        d = c - 8'd191;
        res.ok = 1'b1;
      end else if (c >= 8'd224 && c <= 8'd229) begin
        d = c - 8'd224;
        res.ok = 1'b1;
      end else if (c >= 8'd230) begin
        d = c - 8'd223;
        res.ok = 1'b1;
      end
    end
    res.idx = d[5:0];
    return res;
  endfunction

  // Lowercase letter for an index; yo sits between ye and zhe.
  function automatic logic [7:0] lower_letter(input logic lang, input logic [5:0] idx);
    logic [7:0] res;
    if (lang == LANG_EN) begin
      res = 8'd97 + {2'b00, idx};
    end else if (idx < 6'd6) begin
      res = 8'd224 + {2'b00, idx};
    end else if (idx == 6'd6) begin
      res = 8'd184;
    end else begin
      res = 8'd223 + {2'b00, idx};
    end
    return res;
  endfunction

endpackage

// ===== sv/vigenere_byte_cipher_core.sv =====
// ----------------------------------------------------------------------------
// Vigenere byte cipher core
// Streaming Vigenere cipher over single-byte English or cp1251 Russian text.
// ----------------------------------------------------------------------------
// The core takes one transfer per clock while the output is not stalled. Each
// text byte passes through the middle stage and then the output register. The
// accepting edge registers the item and reads the key store at the current key
// position. When the middle stage moves on, the core maps the letters, does
// the modular add or subtract and loads the output register, which drives
// out_tvalid. Key writes, key restarts and unused actions give no result. Every
// text byte gives exactly one result. The key position steps as each text
// letter is taken, so consecutive letters never wait on each other. Sustained
// rate is one item per cycle while out_tready stays high. The output register
// and the middle stage absorb two results of backpressure. The key store is a
// KEY_MAX-entry byte memory with a registered read. Entries read before they
// are written return whatever the memory holds. Configuration (language,
// direction, key length) is taken every cycle but must only be written while
// the core is idle.
// ----------------------------------------------------------------------------
`include "vigenere_byte_cipher_core_defines.svh"

module vigenere_byte_cipher_core #(
  parameter int KEY_MAX = vbc_pkg::KEY_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] key_slot, [13:6] data_byte, [15:14] zero
  input  logic [1:0]  in_tuser,   // [1:0] action
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] was_letter
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
  localparam logic [vbc_pkg::LEN_W-1:0] KEY_MAX_L = vbc_pkg::LEN_W'(KEY_MAX);

  // configuration
  logic       language_r;
  logic       direction_r;
  logic [6:0] key_length_r;

  // key store and position
  logic [7:0]    key_mem [KEY_MAX];
  logic [AW-1:0] pos_r, pos_nxt;
  logic [7:0]    key_rd_r;

  // middle stage
  logic       b_valid_r, b_valid_nxt;
  logic [7:0] b_byte_r;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_letter_r;

  logic       in_fire, b_advance, cfg_fire;
  logic [5:0] in_slot;
  logic [7:0] in_byte;
  logic [1:0] in_action;

  logic [vbc_pkg::LEN_W-1:0] len_eff, pos_ext, pos_use, pos_inc, slot_ext;
  logic [AW-1:0]             rd_addr;
  vbc_pkg::letter_t          in_let, t_let, k_let;
  logic [5:0]                alpha_n, k_idx;
  logic [6:0]                sum, sum_red;
  logic [7:0]                res_byte;

  assign in_slot   = in_tdata[5:0];
  assign in_byte   = in_tdata[13:6];
  assign in_action = in_tuser;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;

  // Middle stage moves on when the output register is free or being drained.
  assign b_advance = b_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !b_valid_r || b_advance;
  assign in_fire   = in_tvalid && in_tready;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      language_r   <= vbc_pkg::LANG_EN;
      direction_r  <= vbc_pkg::DIR_ENC;
      key_length_r <= 7'd1;
    end else if (cfg_fire) begin
      case (cfg_index)
        vbc_pkg::REG_LANGUAGE:   language_r   <= cfg_data[0];
        vbc_pkg::REG_DIRECTION:  direction_r  <= cfg_data[0];
        vbc_pkg::REG_KEY_LENGTH: key_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- key position ----------------
  // Clamp the length to 1..KEY_MAX; a stale position past the length uses entry 0.
  always_comb begin
    if (key_length_r == 7'd0) begin
      len_eff = vbc_pkg::LEN_W'(1);
    end else if (vbc_pkg::LEN_W'(key_length_r) > KEY_MAX_L) begin
      len_eff = KEY_MAX_L;
    end else begin
      len_eff = vbc_pkg::LEN_W'(key_length_r);
    end
    pos_ext = vbc_pkg::LEN_W'(pos_r);
    pos_use = (pos_ext < len_eff) ? pos_ext : '0;
    pos_inc = pos_use + vbc_pkg::LEN_W'(1);
    rd_addr = pos_use[AW-1:0];
  end

  assign in_let = vbc_pkg::letter_index(language_r, in_byte);

  always_comb begin
    pos_nxt = pos_r;
    if (in_fire) begin
      case (in_action)
        vbc_pkg::ACT_RESTART: pos_nxt = '0;
        vbc_pkg::ACT_TEXT: begin
          // advance only on letters, wrap at the key length
          if (in_let.ok) begin
            pos_nxt = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // ---------------- key store ----------------
  assign slot_ext = vbc_pkg::LEN_W'(in_slot);

  always_ff @(posedge clk) begin
    if (in_fire && in_action == vbc_pkg::ACT_KEY_WRITE && slot_ext < KEY_MAX_L) begin
      key_mem[slot_ext[AW-1:0]] <= in_byte;
    end
  end

  // Read with the item; hold while the item waits in the middle stage.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_rd_r <= key_mem[rd_addr];
    end
  end

  // ---------------- middle stage ----------------
  always_comb begin
    b_valid_nxt = b_valid_r;
    if (in_fire) begin
      b_valid_nxt = (in_action == vbc_pkg::ACT_TEXT);
    end else if (b_advance) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      b_byte_r <= in_byte;
    end
  end

  // ---------------- cipher ----------------
  // Add or subtract the key index modulo the alphabet size; both indexes are
  // below the size, so one conditional subtract reduces the sum.
  always_comb begin
    t_let   = vbc_pkg::letter_index(language_r, b_byte_r);
    k_let   = vbc_pkg::letter_index(language_r, key_rd_r);
    alpha_n = (language_r == vbc_pkg::LANG_EN) ? vbc_pkg::ALPHA_EN : vbc_pkg::ALPHA_RU;
    k_idx   = k_let.ok ? k_let.idx : 6'd0;
    if (direction_r == vbc_pkg::DIR_ENC) begin
      sum = {1'b0, t_let.idx} + {1'b0, k_idx};
    end else begin
      sum = {1'b0, t_let.idx} + {1'b0, alpha_n} - {1'b0, k_idx};
    end
    sum_red  = (sum >= {1'b0, alpha_n}) ? (sum - {1'b0, alpha_n}) : sum;
    res_byte = t_let.ok ? vbc_pkg::lower_letter(language_r, sum_red[5:0]) : b_byte_r;
  end

  // ---------------- output register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b_advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_advance) begin
      out_byte_r   <= res_byte;
      out_letter_r <= t_let.ok;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_letter_r;

  // ---------------- assertions ----------------
  `VBC_ASSERT_ALWAYS(a_no_result_after_reset, $past(!rst_n) |-> !out_valid_r)
  `VBC_ASSERT(a_stall_only_on_full_output, !in_tready |-> (out_valid_r && !out_tready))
  `VBC_ASSERT(a_restart_clears_position,
              (in_fire && in_action == vbc_pkg::ACT_RESTART) |=> (pos_r == '0))

endmodule

// ===== sim/tb_vigenere_byte_cipher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vigenere byte cipher core testbench
// Drives key writes, text bytes and key restarts into the core under English
// and Russian alphabets, both directions and a range of key lengths. Expected
// bytes come from a behavioral cipher model kept in step with every accepted
// transfer or from directed rows, and each result is checked in order.
// ----------------------------------------------------------------------------
module tb_vigenere_byte_cipher_core;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 6;
  localparam int PIPE_LATENCY = 2;
  // Quiet cycles with no transfer anywhere before the run is declared hung.
  localparam int IDLE_LIMIT = 3000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 72;

  // Action code the core does not use; it must be dropped without a result.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Code page landmarks for the alphabets.
  localparam int EN_UPPER_A = 65;
  localparam int EN_UPPER_Z = 90;
  localparam int EN_LOWER_A = 97;
  localparam int EN_LOWER_Z = 122;
  localparam int RU_YO_UPPER = 168;
  localparam int RU_YO_LOWER = 184;
  localparam int RU_UPPER_A = 192;
  localparam int RU_UPPER_YE = 197;
  localparam int RU_UPPER_YA = 223;
  localparam int RU_LOWER_A = 224;
  localparam int RU_LOWER_YE = 229;
  localparam int RU_YO_RANK = 6;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [1:0] sel;     // action for an item, register index for a write
    logic [5:0] slot;
    logic [7:0] data;    // data byte, or register value
    bit         typed;
    logic [7:0] exp_byte;
    logic       exp_letter;
  } plan_row_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       was_letter;
  } cipher_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [5:0] key_slot, [13:6] data_byte, [15:14] zero
  logic [1:0]  in_tuser;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic        out_tuser;  // [0] was_letter
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;

  vigenere_byte_cipher_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Model state: key store, key pointer and the three registers.
  logic [7:0]  model_key [vbc_pkg::KEY_MAX_DEF];
  int          model_pos;
  logic        model_lang;
  logic        model_dir;
  logic [6:0]  model_len;

  cipher_res_t cipher_q[$];
  plan_row_t   plan_q[$];
  cipher_res_t head;
  int          fail_count;
  int          idle_cycles;
  int          rx_hold;
  int          rx_roll;
  bit          rx_steady;
  bit          tx_steady;

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Cipher model
  // ---------------------------------------------------------------------------

  // Case-folded rank of a byte in the alphabet, or -1 for a non-letter.
  function automatic int letter_rank(input logic lang, input logic [7:0] c);
    int v;
    v = int'(c);
    if (lang == vbc_pkg::LANG_EN) begin
      if (v >= EN_UPPER_A && v <= EN_UPPER_Z) return v - EN_UPPER_A;
      if (v >= EN_LOWER_A && v <= EN_LOWER_Z) return v - EN_LOWER_A;
      return -1;
    end
    // Yo sits between ye and zhe, so everything after ye shifts up one rank.
    if (v == RU_YO_UPPER || v == RU_YO_LOWER) return RU_YO_RANK;
    if (v >= RU_UPPER_A && v <= RU_UPPER_YE) return v - RU_UPPER_A;
    if (v > RU_UPPER_YE && v <= RU_UPPER_YA) return v - RU_UPPER_A + 1;
    if (v >= RU_LOWER_A && v <= RU_LOWER_YE) return v - RU_LOWER_A;
    if (v > RU_LOWER_YE) return v - RU_LOWER_A + 1;
    return -1;
  endfunction

  // Lowercase byte for a rank.
  function automatic logic [7:0] lower_glyph(input logic lang, input int r);
    int v;
    if (lang == vbc_pkg::LANG_EN) v = EN_LOWER_A + r;
    else if (r < RU_YO_RANK) v = RU_LOWER_A + r;
    else if (r == RU_YO_RANK) v = RU_YO_LOWER;
    else v = RU_LOWER_A + r - 1;
    return v[7:0];
  endfunction

  // Cipher one text byte and step the key pointer on a letter.
  task automatic cipher_byte(input logic [7:0] c, output cipher_res_t res);
    int t, k, n, len, pos, r;
    t = letter_rank(model_lang, c);
    if (t < 0) begin
      res.out_byte   = c;
      res.was_letter = 1'b0;
    end else begin
      len = (model_len == 0) ? 1 :
            (model_len > vbc_pkg::KEY_MAX_DEF) ? vbc_pkg::KEY_MAX_DEF : int'(model_len);
      // A pointer left past a shortened key falls back to entry zero.
      pos = (model_pos < len) ? model_pos : 0;
      k = letter_rank(model_lang, model_key[pos]);
      if (k < 0) k = 0;
      n = (model_lang == vbc_pkg::LANG_EN) ? int'(vbc_pkg::ALPHA_EN) : int'(vbc_pkg::ALPHA_RU);
      r = (model_dir == vbc_pkg::DIR_ENC) ? (t + k) % n : (t + n - k) % n;
      model_pos = (pos + 1 >= len) ? 0 : pos + 1;
      res.out_byte   = lower_glyph(model_lang, r);
      res.was_letter = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Random letter of an alphabet in either case.
  function automatic logic [7:0] pick_letter(input logic lang);
    int idx;
    bit cap;
    cap = 1'($urandom_range(0, 1));
    if (lang == vbc_pkg::LANG_EN) begin
      idx = $urandom_range(0, int'(vbc_pkg::ALPHA_EN) - 1);
      return 8'(idx + (cap ? EN_UPPER_A : EN_LOWER_A));
    end
    idx = $urandom_range(0, int'(vbc_pkg::ALPHA_RU) - 1);
    if (idx == RU_YO_RANK) return cap ? 8'(RU_YO_UPPER) : 8'(RU_YO_LOWER);
    if (idx < RU_YO_RANK) return 8'(idx + (cap ? RU_UPPER_A : RU_LOWER_A));
    return 8'(idx - 1 + (cap ? RU_UPPER_A : RU_LOWER_A));
  endfunction

  // Mostly back-to-back transfers, some short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic plan_item(input logic [1:0] act, input logic [5:0] slot,
                           input logic [7:0] data);
    plan_row_t row;
    row = '{ROW_ITEM, act, slot, data, 1'b0, 8'd0, 1'b0};
    plan_q.push_back(row);
  endtask

  task automatic plan_typed(input logic [7:0] data, input logic [7:0] b, input logic l);
    plan_row_t row;
    row = '{ROW_ITEM, vbc_pkg::ACT_TEXT, 6'd0, data, 1'b1, b, l};
    plan_q.push_back(row);
  endtask

  task automatic plan_reg(input logic [1:0] idx, input logic [6:0] val);
    plan_row_t row;
    row = '{ROW_REG, idx, 6'd0, {1'b0, val}, 1'b0, 8'd0, 1'b0};
    plan_q.push_back(row);
  endtask

  // Offer one item, hold it until the transfer, then update the model.
  task automatic send_item(input logic [1:0] act, input logic [5:0] slot,
                           input logic [7:0] data, input bit typed,
                           input cipher_res_t typed_res);
    cipher_res_t res;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, data, slot};
    do @(posedge clk); while (!in_tready);
    case (act)
      vbc_pkg::ACT_KEY_WRITE: model_key[slot] = data;
      vbc_pkg::ACT_RESTART:   model_pos = 0;
      vbc_pkg::ACT_TEXT: begin
        cipher_byte(data, res);
        cipher_q.push_back(typed ? typed_res : res);
      end
      default: ;
    endcase
  endtask

  task automatic send_gap();
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending, let every result arrive, then cover items still in flight
  // that produce no result.
  task automatic drain_core();
    in_tvalid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no extra edge.
  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vbc_pkg::REG_LANGUAGE:   model_lang = val[0];
      vbc_pkg::REG_DIRECTION:  model_dir  = val[0];
      vbc_pkg::REG_KEY_LENGTH: model_len  = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Result side: randomized backpressure and in-order checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= 1'b0;
    end else if (rx_steady) begin
      out_tready <= 1'b1;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 12) begin
        rx_hold <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else if (rx_roll < 15) begin
        rx_hold <= $urandom_range(10, 40);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected result, out_byte %0d was_letter %0d",
                 $time, out_tdata, out_tuser);
        fail_count++;
      end else begin
        head = cipher_q.pop_front();
        if (out_tdata !== head.out_byte) begin
          $display("%0t: out_byte mismatch, expected %0d actual %0d",
                   $time, head.out_byte, out_tdata);
          fail_count++;
        end
        if (out_tuser !== head.was_letter) begin
          $display("%0t: was_letter mismatch, expected %0d actual %0d",
                   $time, head.was_letter, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: reset the count on any transfer, give up after a long quiet stretch.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("vigenere_byte_cipher_core verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    plan_row_t   row;
    cipher_res_t typed_res;
    int          roll;
    logic [6:0]  len_pick [PHASES];

    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = vbc_pkg::ACT_KEY_WRITE;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = vbc_pkg::REG_LANGUAGE;
    cfg_data = '0;
    fail_count = 0;
    idle_cycles = 0;
    rx_hold = 0;
    rx_steady = 1'b0;
    tx_steady = 1'b0;
    model_pos = 0;
    model_lang = vbc_pkg::LANG_EN;
    model_dir = vbc_pkg::DIR_ENC;
    model_len = 7'd1;
    foreach (model_key[i]) model_key[i] = 8'd0;

    // Directed rows. Entry zero is written before any letter reads it.
    plan_item(vbc_pkg::ACT_KEY_WRITE, 6'd0, 8'd97);  // key 'a', no shift
    plan_typed(8'd65, 8'd97, 1'b1);                  // 'A' folds to 'a'
    plan_typed(8'd122, 8'd122, 1'b1);                // 'z'
    plan_typed(8'd0, 8'd0, 1'b0);                    // lowest byte passes
    plan_typed(8'd255, 8'd255, 1'b0);                // not a letter in English
    plan_item(ACT_UNUSED, 6'd63, 8'd255);            // dropped, no result
    plan_item(vbc_pkg::ACT_KEY_WRITE, 6'd0, 8'd66);  // uppercase key 'B'
    plan_typed(8'd122, 8'd97, 1'b1);                 // 'z' + 1 wraps to 'a'
    plan_reg(vbc_pkg::REG_DIRECTION, 7'd1);
    plan_typed(8'd97, 8'd122, 1'b1);                 // 'a' - 1 wraps to 'z'
    plan_item(vbc_pkg::ACT_KEY_WRITE, 6'd1, 8'd53);  // non-letter key acts as no shift
    plan_item(vbc_pkg::ACT_KEY_WRITE, 6'd2, 8'd90);
    plan_item(vbc_pkg::ACT_KEY_WRITE, 6'd3, 8'd113);
    plan_reg(vbc_pkg::REG_KEY_LENGTH, 7'd4);
    plan_item(vbc_pkg::ACT_TEXT, 6'd0, 8'd72);
    plan_item(vbc_pkg::ACT_TEXT, 6'd0, 8'd105);
    plan_item(vbc_pkg::ACT_TEXT, 6'd0, 8'd107);
    // Shrink the key below the pointer: next letter takes entry zero.
    plan_reg(vbc_pkg::REG_KEY_LENGTH, 7'd2);
    plan_item(vbc_pkg::ACT_TEXT, 6'd0, 8'd81);
    plan_item(vbc_pkg::ACT_RESTART, 6'd0, 8'd0);
    plan_item(vbc_pkg::ACT_TEXT, 6'd0, 8'd119);
    plan_reg(vbc_pkg::REG_KEY_LENGTH, 7'd0);         // zero length acts as one
    plan_reg(vbc_pkg::REG_LANGUAGE, 7'd1);
    plan_reg(vbc_pkg::REG_DIRECTION, 7'd0);
    plan_item(vbc_pkg::ACT_KEY_WRITE, 6'd0, 8'd168); // capital yo as key
    plan_item(vbc_pkg::ACT_TEXT, 6'd0, 8'd255);
    plan_item(vbc_pkg::ACT_TEXT, 6'd0, 8'd184);
    plan_item(vbc_pkg::ACT_TEXT, 6'd0, 8'd200);
    plan_typed(8'd150, 8'd150, 1'b0);                // odd high byte
    plan_typed(8'd65, 8'd65, 1'b0);                  // Latin byte in Russian mode

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == ROW_REG) begin
        drain_core();
        write_reg(row.sel, row.data[6:0]);
        cfg_valid <= 1'b0;
      end else begin
        typed_res = '{row.exp_byte, row.exp_letter};
        send_item(row.sel, row.slot, row.data, row.typed, typed_res);
        send_gap();
      end
    end

    // Fill the whole store so every key length reads written entries only.
    typed_res = '{8'd0, 1'b0};
    for (int s = 0; s < vbc_pkg::KEY_MAX_DEF; s++) begin
      roll = $urandom_range(0, 9);
      send_item(vbc_pkg::ACT_KEY_WRITE, 6'(s),
                (roll == 0) ? 8'($urandom_range(0, 255)) : pick_letter(roll[0]),
                1'b0, typed_res);
      send_gap();
    end

    len_pick = '{7'd1, 7'd64, 7'd127, 7'd0, 7'd65, 7'($urandom_range(1, 64)),
                 7'($urandom_range(0, 127)), 7'($urandom_range(2, 8))};

    for (int p = 0; p < PHASES; p++) begin
      drain_core();
      write_reg(vbc_pkg::REG_LANGUAGE, {6'd0, p[0]});
      write_reg(vbc_pkg::REG_DIRECTION, {6'd0, p[1]});
      write_reg(vbc_pkg::REG_KEY_LENGTH, len_pick[p]);
      cfg_valid <= 1'b0;
      // One phase runs flat out on both sides.
      rx_steady = (p == 5);
      tx_steady = (p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          roll = $urandom_range(0, 9);
          send_item(vbc_pkg::ACT_TEXT, 6'($urandom_range(0, 63)),
                    (roll < 7) ? pick_letter(model_lang) :
                    (roll < 8) ? pick_letter(~model_lang) : 8'($urandom_range(0, 255)),
                    1'b0, typed_res);
        end else if (roll < 90) begin
          roll = $urandom_range(0, 9);
          send_item(vbc_pkg::ACT_KEY_WRITE, 6'($urandom_range(0, 63)),
                    (roll == 0) ? 8'($urandom_range(0, 255)) : pick_letter(roll[0]),
                    1'b0, typed_res);
        end else if (roll < 96) begin
          send_item(vbc_pkg::ACT_RESTART, 6'($urandom_range(0, 63)),
                    8'($urandom_range(0, 255)), 1'b0, typed_res);
        end else begin
          send_item(ACT_UNUSED, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                    1'b0, typed_res);
        end
        send_gap();
        // Now and then hold the sender until the core has emptied out.
        if (!tx_steady && $urandom_range(0, 59) == 0) drain_core();
      end
    end

    rx_steady = 1'b0;
    tx_steady = 1'b0;
    drain_core();
    repeat (PIPE_LATENCY + 4) @(posedge clk);

    if (fail_count == 0) begin
      $display("vigenere_byte_cipher_core verification clean");
    end else begin
      $display("vigenere_byte_cipher_core verification failed");
    end
    $finish;
  end

endmodule
